@@ rtl/bir_pkg.sv @@
// Shared types and constants for the bilinear image resizer.
// Holds the field widths, register indexes and input kind codes.
// No dependencies.
package bir_pkg;

	// Field widths fixed by the register map and the item format.
	localparam int OLD_DIM_W  = 8;
	localparam int NEW_DIM_W  = 13;
	localparam int COMP_W     = 3;
	localparam int COORD_W    = 12;
	localparam int BYTE_W     = 8;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 3;

	// Q16 step arithmetic.
	localparam int FRAC_W   = 16;
	localparam int STEP_W   = OLD_DIM_W + FRAC_W;
	localparam int WEIGHT_W = FRAC_W + 1;

	// Number of value lanes on the result.
	localparam int NUM_VALUES = 4;
	localparam int LANE_W     = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_OLD_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OLD_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NEW_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NEW_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COMP_COUNT = 3'd4;

	// Input item kinds.
	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_REQUEST = 1'b1;

	typedef logic [BYTE_W-1:0] byte_t;

endpackage

@@ rtl/bir_step_div.sv @@
// Restoring divider that produces the Q16 step along one axis.
// One quotient bit per cycle; depends on bir_pkg.
module bir_step_div import bir_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [STEP_W-1:0] dividend,
	input  logic [NEW_DIM_W-1:0] divisor,
	output logic              busy,
	output logic [STEP_W-1:0] quotient
);

	localparam int CNT_W = $clog2(STEP_W);

	logic [STEP_W-1:0]    quo_q;
	logic [NEW_DIM_W-1:0] rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 run_q;
	logic [NEW_DIM_W:0]   trial;
	logic [NEW_DIM_W:0]   rem_next;
	logic                 ge;

	// One trial subtraction per cycle.
	always_comb begin
		trial    = {rem_q, quo_q[STEP_W-1]};
		ge       = (trial >= {1'b0, divisor});
		rem_next = ge ? (trial - {1'b0, divisor}) : trial;
	end

	// Control: counts the quotient bits still to be produced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= CNT_W'(STEP_W - 1);
		end else if (run_q) begin
			if (cnt_q == '0) begin
				run_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Dividend shifts out at the top while quotient bits shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[STEP_W-2:0], ge};
			rem_q <= rem_next[NEW_DIM_W-1:0];
		end
	end

	assign busy     = run_q;
	assign quotient = quo_q;

endmodule

@@ rtl/bir_store.sv @@
// Source image byte store: one write port and two read ports.
// Read data is registered; depends on bir_pkg.
module bir_store import bir_pkg::*; #(
	parameter int DEPTH  = 65536,
	parameter int ADDR_W = 16
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  byte_t             wr_data,
	input  logic [ADDR_W-1:0] rd_addr_a,
	input  logic [ADDR_W-1:0] rd_addr_b,
	output byte_t             rd_data_a,
	output byte_t             rd_data_b
);

	byte_t mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Two registered read ports.
	always_ff @(posedge clk) begin
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

@@ rtl/bilinear_image_resize.sv @@
// Bilinear image resizer with align-corners mapping. A load beat (kind 0) writes
// one source byte into the store in raster order, components interleaved. A
// request beat (kind 1) returns one output pixel: states S_MAP, S_ROWS and
// S_ADDR map the coordinate through the Q16 steps, then each component passes
// through S_RD_TOP and S_RD_BOT for the paired store reads of its four
// neighbours and S_BLEND1 and S_BLEND2 for the blend multipliers. A request
// outside the new size skips to the result with bad_request set. After any
// configuration write the block stalls its input while the per-axis steps
// are recomputed by bit-serial dividers. A finished result waits in an output
// register, so loads and the next request are taken meanwhile.
// Depends on bir_pkg, bir_step_div and bir_store.
module bilinear_image_resize import bir_pkg::*; #(
	parameter int MAX_WIDTH      = 128,
	parameter int MAX_HEIGHT     = 128,
	parameter int MAX_COMPONENTS = 4,
	parameter int MAX_OUT_DIM    = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  kind,
	input  logic [BYTE_W-1:0]     source_byte,
	input  logic [COORD_W-1:0]    out_x,
	input  logic [COORD_W-1:0]    out_y,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [BYTE_W-1:0]     value_0,
	output logic [BYTE_W-1:0]     value_1,
	output logic [BYTE_W-1:0]     value_2,
	output logic [BYTE_W-1:0]     value_3,
	output logic                  bad_request
);

	localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT * MAX_COMPONENTS;
	localparam int ADDR_W     = $clog2(STORE_SIZE);
	localparam int TOTAL_W    = 2 * OLD_DIM_W + COMP_W;
	localparam int PIX_W      = 2 * OLD_DIM_W + 1;
	localparam int MUL_W      = COORD_W + STEP_W;
	localparam int SUM_W      = BYTE_W + FRAC_W + 1;
	localparam int ACC_W      = SUM_W + WEIGHT_W;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_MAP    = 4'd1;
	localparam logic [3:0] S_ROWS   = 4'd2;
	localparam logic [3:0] S_ADDR   = 4'd3;
	localparam logic [3:0] S_RD_TOP = 4'd4;
	localparam logic [3:0] S_RD_BOT = 4'd5;
	localparam logic [3:0] S_BLEND1 = 4'd6;
	localparam logic [3:0] S_BLEND2 = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	localparam logic [WEIGHT_W-1:0] ONE_Q16 = WEIGHT_W'(1) << FRAC_W;

	// Configuration registers.
	logic [OLD_DIM_W-1:0] old_width_q, old_height_q;
	logic [NEW_DIM_W-1:0] new_width_q, new_height_q;
	logic [COMP_W-1:0]    comp_count_q;
	logic                 div_start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			old_width_q  <= OLD_DIM_W'(1);
			old_height_q <= OLD_DIM_W'(1);
			new_width_q  <= NEW_DIM_W'(1);
			new_height_q <= NEW_DIM_W'(1);
			comp_count_q <= COMP_W'(3);
			div_start_q  <= 1'b0;
		end else begin
			div_start_q <= cfg_write;
			if (cfg_write) begin
				case (cfg_index)
					CFG_OLD_WIDTH:  old_width_q  <= cfg_data[OLD_DIM_W-1:0];
					CFG_OLD_HEIGHT: old_height_q <= cfg_data[OLD_DIM_W-1:0];
					CFG_NEW_WIDTH:  new_width_q  <= cfg_data[NEW_DIM_W-1:0];
					CFG_NEW_HEIGHT: new_height_q <= cfg_data[NEW_DIM_W-1:0];
					CFG_COMP_COUNT: comp_count_q <= cfg_data[COMP_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Dimensions clamped into their usable ranges.
	logic [OLD_DIM_W-1:0] ow, oh;
	logic [NEW_DIM_W-1:0] nw, nh;
	logic [COMP_W-1:0]    nc;

	always_comb begin
		ow = old_width_q;
		if (old_width_q == '0) ow = OLD_DIM_W'(1);
		else if (32'(old_width_q) > MAX_WIDTH) ow = OLD_DIM_W'(MAX_WIDTH);
		oh = old_height_q;
		if (old_height_q == '0) oh = OLD_DIM_W'(1);
		else if (32'(old_height_q) > MAX_HEIGHT) oh = OLD_DIM_W'(MAX_HEIGHT);
		nw = new_width_q;
		if (new_width_q == '0) nw = NEW_DIM_W'(1);
		else if (32'(new_width_q) > MAX_OUT_DIM) nw = NEW_DIM_W'(MAX_OUT_DIM);
		nh = new_height_q;
		if (new_height_q == '0) nh = NEW_DIM_W'(1);
		else if (32'(new_height_q) > MAX_OUT_DIM) nh = NEW_DIM_W'(MAX_OUT_DIM);
		nc = comp_count_q;
		if (comp_count_q == '0) nc = COMP_W'(1);
		else if (32'(comp_count_q) > MAX_COMPONENTS) nc = COMP_W'(MAX_COMPONENTS);
	end

	// Per-axis step dividers, restarted after every configuration write.
	logic              busy_x, busy_y;
	logic [STEP_W-1:0] quo_x, quo_y, step_x, step_y;

	bir_step_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend ({ow - 1'b1, FRAC_W'(0)}),
		.divisor  (nw - 1'b1),
		.busy     (busy_x),
		.quotient (quo_x)
	);

	bir_step_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend ({oh - 1'b1, FRAC_W'(0)}),
		.divisor  (nh - 1'b1),
		.busy     (busy_y),
		.quotient (quo_y)
	);

	// An output size of one samples index 0 along the whole axis.
	assign step_x = (nw == NEW_DIM_W'(1)) ? '0 : quo_x;
	assign step_y = (nh == NEW_DIM_W'(1)) ? '0 : quo_y;

	// Handshake.
	logic [3:0] state_q;
	logic       in_fire, out_fire, out_load;
	logic       out_valid_q;

	assign in_stall = (state_q != S_IDLE) || div_start_q || busy_x || busy_y;
	assign in_fire  = in_valid && !in_stall;
	assign out_fire = out_valid_q && !out_stall;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// Load pointer, wrapping after the full image.
	logic [ADDR_W-1:0]  load_ptr_q, ptr_eff;
	logic [TOTAL_W-1:0] total, ptr_inc;
	logic               wr_en;

	always_comb begin
		total   = TOTAL_W'(ow) * TOTAL_W'(oh) * TOTAL_W'(nc);
		ptr_eff = (TOTAL_W'(load_ptr_q) >= total) ? '0 : load_ptr_q;
		ptr_inc = TOTAL_W'(ptr_eff) + 1'b1;
		wr_en   = in_fire && (kind == KIND_LOAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_ptr_q <= '0;
		end else if (wr_en) begin
			load_ptr_q <= (ptr_inc >= total) ? '0 : ADDR_W'(ptr_inc);
		end
	end

	// Source store.
	logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
	byte_t             rd_data_a, rd_data_b;
	logic [ADDR_W-1:0] a11_s3, a12_s3, a21_s3, a22_s3;
	logic [LANE_W-1:0] comp_q;

	always_comb begin
		if (state_q == S_RD_BOT) begin
			rd_addr_a = a21_s3 + ADDR_W'(comp_q);
			rd_addr_b = a22_s3 + ADDR_W'(comp_q);
		end else begin
			rd_addr_a = a11_s3 + ADDR_W'(comp_q);
			rd_addr_b = a12_s3 + ADDR_W'(comp_q);
		end
	end

	bir_store #(
		.DEPTH  (STORE_SIZE),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (ptr_eff),
		.wr_data   (source_byte),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	// Coordinate mapping: clamp the integer parts and pick the neighbours.
	logic [COORD_W-1:0]   ox_q, oy_q;
	logic [MUL_W-1:0]     sx_s1, sy_s1;
	logic [OLD_DIM_W-1:0] x1, x2, y1, y2;
	logic [FRAC_W-1:0]    fx, fy;

	always_comb begin
		x1 = sx_s1[OLD_DIM_W+FRAC_W-1:FRAC_W];
		fx = sx_s1[FRAC_W-1:0];
		if (sx_s1[MUL_W-1:FRAC_W] > (MUL_W-FRAC_W)'(ow - 1'b1)) begin
			x1 = ow - 1'b1;
			fx = '0;
		end
		y1 = sy_s1[OLD_DIM_W+FRAC_W-1:FRAC_W];
		fy = sy_s1[FRAC_W-1:0];
		if (sy_s1[MUL_W-1:FRAC_W] > (MUL_W-FRAC_W)'(oh - 1'b1)) begin
			y1 = oh - 1'b1;
			fy = '0;
		end
		x2 = (x1 == ow - 1'b1) ? x1 : x1 + 1'b1;
		y2 = (y1 == oh - 1'b1) ? y1 : y1 + 1'b1;
	end

	// Blend arithmetic.
	logic [OLD_DIM_W-1:0] x1_s2, x2_s2;
	logic [PIX_W-1:0]     row1_s2, row2_s2;
	logic [FRAC_W-1:0]    fx_s2, fy_s2;
	logic [WEIGHT_W-1:0]  wx0, wx1, wy0, wy1;
	byte_t                p11_q, p12_q;
	logic [SUM_W-1:0]     top_s4, bot_s4;
	logic [ACC_W-1:0]     acc;
	logic                 bad_q;
	byte_t                val_q [NUM_VALUES];

	always_comb begin
		wx1 = {1'b0, fx_s2};
		wx0 = ONE_Q16 - wx1;
		wy1 = {1'b0, fy_s2};
		wy0 = ONE_Q16 - wy1;
		acc = ACC_W'(top_s4) * ACC_W'(wy0) + ACC_W'(bot_s4) * ACC_W'(wy1);
	end

	// Request sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			comp_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire && kind == KIND_REQUEST) begin
						comp_q <= '0;
						if ({1'b0, out_x} >= nw || {1'b0, out_y} >= nh) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_MAP;
						end
					end
				end
				S_MAP:    state_q <= S_ROWS;
				S_ROWS:   state_q <= S_ADDR;
				S_ADDR:   state_q <= S_RD_TOP;
				S_RD_TOP: state_q <= S_RD_BOT;
				S_RD_BOT: state_q <= S_BLEND1;
				S_BLEND1: state_q <= S_BLEND2;
				S_BLEND2: begin
					if ({1'b0, comp_q} == nc - 1'b1) begin
						state_q <= S_DONE;
					end else begin
						comp_q  <= comp_q + 1'b1;
						state_q <= S_RD_TOP;
					end
				end
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request datapath registers.
	always_ff @(posedge clk) begin
		if (in_fire && kind == KIND_REQUEST) begin
			ox_q  <= out_x;
			oy_q  <= out_y;
			bad_q <= ({1'b0, out_x} >= nw) || ({1'b0, out_y} >= nh);
			for (int i = 0; i < NUM_VALUES; i++) val_q[i] <= '0;
		end
		if (state_q == S_MAP) begin
			sx_s1 <= MUL_W'(ox_q) * MUL_W'(step_x);
			sy_s1 <= MUL_W'(oy_q) * MUL_W'(step_y);
		end
		if (state_q == S_ROWS) begin
			x1_s2   <= x1;
			x2_s2   <= x2;
			fx_s2   <= fx;
			fy_s2   <= fy;
			row1_s2 <= PIX_W'(y1) * PIX_W'(ow);
			row2_s2 <= PIX_W'(y2) * PIX_W'(ow);
		end
		if (state_q == S_ADDR) begin
			a11_s3 <= ADDR_W'(TOTAL_W'(row1_s2 + PIX_W'(x1_s2)) * TOTAL_W'(nc));
			a12_s3 <= ADDR_W'(TOTAL_W'(row1_s2 + PIX_W'(x2_s2)) * TOTAL_W'(nc));
			a21_s3 <= ADDR_W'(TOTAL_W'(row2_s2 + PIX_W'(x1_s2)) * TOTAL_W'(nc));
			a22_s3 <= ADDR_W'(TOTAL_W'(row2_s2 + PIX_W'(x2_s2)) * TOTAL_W'(nc));
		end
		if (state_q == S_RD_BOT) begin
			p11_q <= rd_data_a;
			p12_q <= rd_data_b;
		end
		if (state_q == S_BLEND1) begin
			top_s4 <= SUM_W'(p11_q) * SUM_W'(wx0) + SUM_W'(p12_q) * SUM_W'(wx1);
			bot_s4 <= SUM_W'(rd_data_a) * SUM_W'(wx0) + SUM_W'(rd_data_b) * SUM_W'(wx1);
		end
		if (state_q == S_BLEND2) begin
			val_q[comp_q] <= acc[2*FRAC_W+BYTE_W-1:2*FRAC_W];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			value_0     <= val_q[0];
			value_1     <= val_q[1];
			value_2     <= val_q[2];
			value_3     <= val_q[3];
			bad_request <= bad_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule
